@@ rtl/core/mesh_unique_edge_extractor_defines.svh @@
// Assertion macros for the mesh unique edge extractor.
// Included by the top level; no other dependencies.
`ifndef MESH_UNIQUE_EDGE_EXTRACTOR_DEFINES_SVH
`define MESH_UNIQUE_EDGE_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MUE_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define MUE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MUE_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define MUE_ASSERT_NEXT(name, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/mue_pkg.sv @@
// Shared constants and types for the mesh unique edge extractor.
// No dependencies.
`timescale 1ns / 1ps

package mue_pkg;

  localparam int IDX_W       = 32;
  localparam int KEY_W       = 2 * IDX_W;
  localparam int INDEX_BITS  = 32;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int EDGES       = 3;

  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  typedef struct packed {
    logic             clear;
    logic             lookup;
    logic [KEY_W-1:0] key;
  } mue_tbl_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic is_new;
    logic full;
  } mue_tbl_status_t;

endpackage

@@ rtl/core/mesh_unique_edge_extractor.sv @@
// Unique edge extractor: one triangle in, up to three new edges out.
// Each edge is looked up in the single-port hash table, probing on through slots on a collision.
// A triangle with no new edge emits nothing; else its new edges go out in turn, the last with m_tlast.
// Output stalls hold the block until they clear. Reset and new_mesh start a sweep that clears
// all 4096 table slots; s_tready low meanwhile. Depends on mue_pkg, mue_edge_table.
`timescale 1ns / 1ps
`include "mesh_unique_edge_extractor_defines.svh"

module mesh_unique_edge_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // corner_a, corner_b, corner_c
  input  logic        s_tuser,  // new_mesh
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // edge_low, edge_high
  output logic        m_tlast,  // last_of_triangle
  output logic        m_tuser   // store_full
);
  import mue_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_ISSUE, S_WAIT, S_OUT} state_t;

  state_t           state;
  mue_tbl_req_t     tbl_req;
  mue_tbl_status_t  tbl_status;
  logic [IDX_W-1:0] corner_a;
  logic [IDX_W-1:0] corner_b;
  logic [IDX_W-1:0] corner_c;
  logic [1:0]       edge_idx;
  logic [1:0]       n_res;
  logic [1:0]       rd_idx;
  logic [1:0]       sel;
  logic [IDX_W-1:0] cur_lo;
  logic [IDX_W-1:0] cur_hi;
  logic [IDX_W-1:0] res_lo   [EDGES];
  logic [IDX_W-1:0] res_hi   [EDGES];
  logic             res_full [EDGES];
  logic [IDX_W-1:0] v0;
  logic [IDX_W-1:0] v1;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic             in_xfer;

  mue_edge_table u_table (
    .clk    (clk),
    .rst    (rst),
    .req    (tbl_req),
    .status (tbl_status)
  );

  always_comb begin
    case (edge_idx)
      2'd0: begin
        v0 = corner_a;
        v1 = corner_b;
      end
      2'd1: begin
        v0 = corner_b;
        v1 = corner_c;
      end
      default: begin
        v0 = corner_c;
        v1 = corner_a;
      end
    endcase
    lo = (v0 < v1) ? v0 : v1;
    hi = (v0 < v1) ? v1 : v0;
  end

  assign s_tready       = (state == S_IDLE) && tbl_status.idle;
  assign in_xfer        = s_tvalid && s_tready;
  assign tbl_req.clear  = in_xfer && s_tuser;
  assign tbl_req.lookup = (state == S_ISSUE);
  assign tbl_req.key    = {lo, hi};
  assign sel            = m_tvalid ? rd_idx + 1'b1 : rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      edge_idx <= '0;
      n_res    <= '0;
      rd_idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            corner_a <= s_tdata[31:0] & IDX_MASK;
            corner_b <= s_tdata[63:32] & IDX_MASK;
            corner_c <= s_tdata[95:64] & IDX_MASK;
            edge_idx <= '0;
            n_res    <= '0;
            rd_idx   <= '0;
            state    <= s_tuser ? S_CLEAR : S_ISSUE;
          end
        end
        S_CLEAR: begin
          if (tbl_status.idle) begin
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          cur_lo <= lo;
          cur_hi <= hi;
          state  <= S_WAIT;
        end
        S_WAIT: begin
          if (tbl_status.done) begin
            if (tbl_status.is_new) begin
              res_lo[n_res]   <= cur_lo;
              res_hi[n_res]   <= cur_hi;
              res_full[n_res] <= tbl_status.full;
              n_res           <= n_res + 1'b1;
            end
            if (edge_idx == 2'(EDGES - 1)) begin
              state <= (tbl_status.is_new || (n_res != '0)) ? S_OUT : S_IDLE;
            end else begin
              edge_idx <= edge_idx + 1'b1;
              state    <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (m_tvalid && m_tlast) begin
              m_tvalid <= 1'b0;
              state    <= S_IDLE;
            end else begin
              m_tdata  <= {res_hi[sel], res_lo[sel]};
              m_tuser  <= res_full[sel];
              m_tlast  <= (sel == n_res - 1'b1);
              m_tvalid <= 1'b1;
              rd_idx   <= sel;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MUE_ASSERT_IMPL(a_ready_no_result, clk, rst, s_tready, !m_tvalid, "ready while result pending")
  `MUE_ASSERT_NEXT(a_last_frees_input, clk, rst, m_tvalid && m_tready && m_tlast, s_tready, "not ready after last transfer")
  `MUE_ASSERT_IMPL(a_done_in_wait, clk, rst, tbl_status.done, state == S_WAIT, "table answer outside wait")
  `MUE_ASSERT_IMPL(a_lookup_idle, clk, rst, tbl_req.lookup, tbl_status.idle, "lookup while table busy")

endmodule

@@ rtl/core/mue_edge_table.sv @@
// Hashed seen-edge table: single-port RAM, linear probing, clearing sweep.
// Depends on mue_pkg.
`timescale 1ns / 1ps

module mue_edge_table (
  input  logic                   clk,
  input  logic                   rst,
  input  mue_pkg::mue_tbl_req_t  req,
  output mue_pkg::mue_tbl_status_t status
);
  import mue_pkg::*;

  localparam int AW1 = ADDR_W + 1;

  typedef enum logic [1:0] {T_CLEAR, T_IDLE, T_READ, T_CHECK} tbl_state_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } slot_t;

  slot_t             mem [STORE_DEPTH];
  slot_t             rdata;
  slot_t             wdata;
  logic              mem_we;
  tbl_state_t        state;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] addr_inc;
  logic [ADDR_W-1:0] probes;
  logic [KEY_W-1:0]  key_r;
  logic              done;
  logic              is_new;
  logic              full;
  logic              hit;
  logic              empty;

  // xor-fold of the key with the high index rotated into the low one
  function automatic logic [ADDR_W-1:0] slot_hash(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0]  m;
    logic [ADDR_W-1:0] h;
    logic [AW1-1:0]    hw;
    m = {k[KEY_W-1:IDX_W], k[IDX_W-1:0] ^ {k[IDX_W+26:IDX_W], k[KEY_W-1:IDX_W+27]}};
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % ADDR_W] = h[i % ADDR_W] ^ m[i];
    end
    hw = {1'b0, h};
    if (hw >= AW1'(STORE_DEPTH)) begin
      hw = hw - AW1'(STORE_DEPTH);
    end
    return hw[ADDR_W-1:0];
  endfunction

  always_comb begin
    addr_inc = (addr == ADDR_W'(STORE_DEPTH - 1)) ? '0 : addr + 1'b1;
    hit      = rdata.valid && (rdata.key == key_r);
    empty    = !rdata.valid;
    mem_we   = (state == T_CLEAR) || ((state == T_CHECK) && empty);
    wdata    = (state == T_CLEAR) ? '0 : {1'b1, key_r};
  end

  // read-first single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_CLEAR;
      addr   <= '0;
      probes <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_CLEAR: begin
          if (addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= T_IDLE;
          end
          addr <= addr_inc;
        end
        T_IDLE: begin
          if (req.clear) begin
            state <= T_CLEAR;
            addr  <= '0;
          end else if (req.lookup) begin
            key_r  <= req.key;
            addr   <= slot_hash(req.key);
            probes <= '0;
            state  <= T_READ;
          end
        end
        T_READ: begin
          state <= T_CHECK;
        end
        T_CHECK: begin
          if (hit) begin
            done   <= 1'b1;
            is_new <= 1'b0;
            full   <= 1'b0;
            state  <= T_IDLE;
          end else if (empty) begin
            done   <= 1'b1;
            is_new <= 1'b1;
            full   <= 1'b0;
            state  <= T_IDLE;
          end else if (probes == ADDR_W'(STORE_DEPTH - 1)) begin
            // every slot taken and none matches
            done   <= 1'b1;
            is_new <= 1'b1;
            full   <= 1'b1;
            state  <= T_IDLE;
          end else begin
            probes <= probes + 1'b1;
            addr   <= addr_inc;
            state  <= T_READ;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign status.idle   = (state == T_IDLE);
  assign status.done   = done;
  assign status.is_new = is_new;
  assign status.full   = full;

endmodule

@@ bench/mesh_unique_edge_extractor_tb.sv @@
// Self-checking bench for mesh_unique_edge_extractor: drives triangles, predicts
// the unique edges each one should produce, and checks every output transfer.
// Depends on mue_pkg and the RTL of mesh_unique_edge_extractor.
`timescale 1ns / 1ps

module mesh_unique_edge_extractor_tb;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        last;
    logic        full;
  } edge_rec_t;

  // Tracks recorded edge keys in insertion order and queues the edges
  // each accepted triangle should emit.
  class edge_dedup_board;
    edge_rec_t   pending_edges[$];
    logic [63:0] recorded_keys[mue_pkg::STORE_DEPTH];
    int          n_recorded;
    int          errors;
    int          n_checked;
    int          n_full;

    function bit key_recorded(logic [63:0] key);
      for (int i = 0; i < n_recorded; i++)
        if (recorded_keys[i] == key) return 1'b1;
      return 1'b0;
    endfunction

    function void note_triangle(bit new_mesh, logic [31:0] a, logic [31:0] b,
                                logic [31:0] c);
      logic [31:0] v[3];
      logic [31:0] lo, hi;
      logic [63:0] key;
      edge_rec_t   found[3];
      int          n;
      if (new_mesh) n_recorded = 0;
      v[0] = a & mue_pkg::IDX_MASK;
      v[1] = b & mue_pkg::IDX_MASK;
      v[2] = c & mue_pkg::IDX_MASK;
      n = 0;
      for (int e = 0; e < 3; e++) begin
        lo  = (v[e] < v[(e + 1) % 3]) ? v[e] : v[(e + 1) % 3];
        hi  = (v[e] < v[(e + 1) % 3]) ? v[(e + 1) % 3] : v[e];
        key = {lo, hi};
        if (!key_recorded(key)) begin
          found[n].lo   = lo;
          found[n].hi   = hi;
          found[n].last = 1'b0;
          found[n].full = (n_recorded >= mue_pkg::STORE_DEPTH);
          if (!found[n].full) begin
            recorded_keys[n_recorded] = key;
            n_recorded++;
          end
          n++;
        end
      end
      if (n > 0) found[n - 1].last = 1'b1;
      for (int i = 0; i < n; i++) pending_edges = {pending_edges, found[i]};
    endfunction

    function void check_edge(logic [31:0] lo, logic [31:0] hi, logic last,
                             logic full);
      edge_rec_t want;
      if (pending_edges.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected edge lo=%h hi=%h last=%b full=%b",
                   $realtime, lo, hi, last, full);
        return;
      end
      want = pending_edges.pop_front();
      n_checked++;
      if (full === 1'b1) n_full++;
      if (want.lo !== lo || want.hi !== hi || want.last !== last || want.full !== full) begin
        errors++;
        if (errors <= 10)
          $display("%0t: edge mismatch exp lo=%h hi=%h last=%b full=%b, got lo=%h hi=%h last=%b full=%b",
                   $realtime, want.lo, want.hi, want.last, want.full, lo, hi, last, full);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;  // corner_a, corner_b, corner_c
  logic        s_tuser = 1'b0;  // new_mesh
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;  // edge_low, edge_high
  logic        m_tlast;  // last_of_triangle
  logic        m_tuser;  // store_full

  edge_dedup_board sb = new();

  int          n_tri = 0;
  int          n_mesh = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int          rx_wait = 0;
  logic [31:0] vertex_pool[10];

  mesh_unique_edge_extractor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: random stall after each transfer, with stretches of none.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else if (m_tvalid && m_tready) begin
      sb.check_edge(m_tdata[31:0], m_tdata[63:32], m_tlast, m_tuser);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 12);
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      if (rx_wait > 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      if (rx_wait > 0) rx_wait--;
      else m_tready <= 1'b1;
    end
  end

  // Valid stays high across back-to-back triangles; only dropped for a gap.
  task automatic send_tri(input bit new_mesh, input logic [31:0] a,
                          input logic [31:0] b, input logic [31:0] c);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= new_mesh;
    s_tdata  <= {c, b, a};
    do @(posedge clk); while (!s_tready);
    sb.note_triangle(new_mesh, a, b, c);
    n_tri++;
    if (new_mesh) n_mesh++;
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_edges.size() != 0) @(posedge clk);
  endtask

  function automatic void refresh_pool();
    for (int i = 0; i < 10; i++) begin
      case ($urandom_range(0, 15))
        0:       vertex_pool[i] = 32'h0;
        1:       vertex_pool[i] = 32'hFFFF_FFFF;
        default: vertex_pool[i] = $urandom;
      endcase
    end
  endfunction

  function automatic logic [31:0] pick_vertex();
    return vertex_pool[$urandom_range(0, 9)];
  endfunction

  task automatic run_directed();
    send_tri(1, 32'h0, 32'h0, 32'h0);
    send_tri(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_tri(0, 32'h0, 32'hFFFF_FFFF, 32'h1);
    send_tri(0, 32'h1, 32'hFFFF_FFFF, 32'h0);  // reversed: nothing new
    send_tri(0, 32'hFFFF_FFFF, 32'h0, 32'h2);
    send_tri(0, 32'h5, 32'h3, 32'h5);
    send_tri(0, 32'h7, 32'h7, 32'h8);
    send_tri(0, 32'h8, 32'h9, 32'h7);
    send_tri(0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    send_tri(0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
    send_tri(1, 32'h0, 32'hFFFF_FFFF, 32'h1);  // cleared store: all re-emitted
    send_tri(0, 32'h0, 32'h0, 32'h0);
    send_tri(0, 32'hFFFF_FFFF, 32'h1, 32'h0);
    send_tri(1, 32'h1234_5678, 32'h1234_5678, 32'h9ABC_DEF0);
  endtask

  task automatic run_random(input int count);
    bit          new_mesh;
    logic [31:0] a, b, c, x, y;
    refresh_pool();
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_outputs();
      new_mesh = ($urandom_range(0, 23) == 0);
      if (new_mesh) refresh_pool();
      x = pick_vertex();
      y = pick_vertex();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          a = x; b = y; c = pick_vertex();
        end
        6, 7: begin
          a = x; b = $urandom; c = y;
        end
        8: begin
          a = $urandom; b = $urandom; c = $urandom;
        end
        default: begin
          if ($urandom_range(0, 1)) y = $urandom;
          case ($urandom_range(0, 3))
            0:       begin a = x; b = x; c = y; end
            1:       begin a = y; b = x; c = x; end
            2:       begin a = x; b = y; c = x; end
            default: begin a = x; b = x; c = x; end
          endcase
        end
      endcase
      send_tri(new_mesh, a, b, c);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(396);
    drain_outputs();
    while (sb.pending_edges.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Covered %0d triangles over %0d new meshes; %0d edges checked, %0d flagged store full.",
             n_tri, n_mesh, sb.n_checked, sb.n_full);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("Timeout with %0d edges still outstanding", sb.pending_edges.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
